/* rtl/core/htfd_pkg.sv */
// shared types, constants and crc helper for the humidity and temperature frame decoder
package htfd_pkg;

  localparam int unsigned FRAME_BYTES = 7;

  localparam logic [7:0] CRC_INIT = 8'hFF;
  localparam logic [7:0] CRC_POLY = 8'h31;

  // byte positions inside a reply frame
  localparam logic [2:0] POS_STATUS   = 3'd0;
  localparam logic [2:0] POS_HUM_HI   = 3'd1;
  localparam logic [2:0] POS_HUM_MID  = 3'd2;
  localparam logic [2:0] POS_SPLIT    = 3'd3;
  localparam logic [2:0] POS_TEMP_MID = 3'd4;
  localparam logic [2:0] POS_TEMP_LO  = 3'd5;
  localparam logic [2:0] POS_CRC      = 3'(FRAME_BYTES - 1);

  // configuration register indexes
  localparam logic [1:0] CFG_TEMP_MIN = 2'd0;
  localparam logic [1:0] CFG_TEMP_MAX = 2'd1;
  localparam logic [1:0] CFG_HUM_MAX  = 2'd2;

  localparam logic signed [14:0] TEMP_MIN_RESET = -15'sd4000;
  localparam logic signed [14:0] TEMP_MAX_RESET = 15'sd8000;
  localparam logic [13:0]        HUM_MAX_RESET  = 14'd10000;

  localparam logic [13:0]        HUM_SCALE   = 14'd10000;
  localparam logic [14:0]        TEMP_SCALE  = 15'd20000;
  localparam logic signed [15:0] TEMP_OFFSET = 16'sd5000;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_CRC   = 2'd1,
    STATUS_RANGE = 2'd2,
    STATUS_ZERO  = 2'd3
  } status_e;

  typedef struct packed {
    logic signed [14:0] temp_min;
    logic signed [14:0] temp_max;
    logic [13:0]        hum_max;
  } cfg_t;

  typedef struct packed {
    logic [19:0] raw_hum;
    logic [19:0] temp_raw;
    logic        crc_err;
  } frame_t;

  // one byte of crc-8, msb first
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

/* rtl/core/htfd_frame.sv */
// input register, byte position tracking, crc and raw field assembly
module htfd_frame (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              frame_start_i,
  input  logic [7:0]        data_byte_i,
  output logic              frame_valid_o,
  input  logic              frame_ready_i,
  output htfd_pkg::frame_t  frame_o
);
  import htfd_pkg::*;

  logic        in_valid_q;
  logic        start_q;
  logic [7:0]  byte_q;
  logic [2:0]  count_q, count_d;
  logic [7:0]  crc_q, crc_d;
  logic [19:0] raw_hum_q, raw_hum_d;
  logic [19:0] temp_raw_q, temp_raw_d;
  logic        frame_valid_q;
  frame_t      frame_q;

  logic [2:0]  pos;
  logic [7:0]  crc_cur;
  logic        is_last;
  logic        go;

  always_comb begin
    if (start_q || (count_q >= 3'(FRAME_BYTES))) begin
      pos = POS_STATUS;
    end else begin
      pos = count_q;
    end
  end

  assign crc_cur    = (pos == POS_STATUS) ? CRC_INIT : crc_q;
  assign is_last    = (pos == POS_CRC);
  // only the crc byte needs room downstream
  assign go         = in_valid_q && (!is_last || !frame_valid_q || frame_ready_i);
  assign in_ready_o = !in_valid_q || go;

  always_comb begin
    raw_hum_d  = raw_hum_q;
    temp_raw_d = temp_raw_q;
    case (pos)
      POS_HUM_HI:   raw_hum_d[19:12] = byte_q;
      POS_HUM_MID:  raw_hum_d[11:4]  = byte_q;
      POS_SPLIT: begin
        raw_hum_d[3:0]    = byte_q[7:4];
        temp_raw_d[19:16] = byte_q[3:0];
      end
      POS_TEMP_MID: temp_raw_d[15:8] = byte_q;
      POS_TEMP_LO:  temp_raw_d[7:0]  = byte_q;
      default: ;
    endcase
    if (is_last) begin
      crc_d   = CRC_INIT;
      count_d = POS_STATUS;
    end else begin
      crc_d   = crc8_byte(crc_cur, byte_q);
      count_d = pos + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q    <= 1'b0;
      count_q       <= 3'd0;
      crc_q         <= CRC_INIT;
      raw_hum_q     <= 20'd0;
      temp_raw_q    <= 20'd0;
      frame_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (go) begin
        count_q    <= count_d;
        crc_q      <= crc_d;
        raw_hum_q  <= raw_hum_d;
        temp_raw_q <= temp_raw_d;
      end
      if (go && is_last) begin
        frame_valid_q <= 1'b1;
      end else if (frame_ready_i) begin
        frame_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      start_q <= frame_start_i;
      byte_q  <= data_byte_i;
    end
    if (go && is_last) begin
      frame_q.raw_hum  <= raw_hum_q;
      frame_q.temp_raw <= temp_raw_q;
      frame_q.crc_err  <= (crc_cur != byte_q);
    end
  end

  assign frame_valid_o = frame_valid_q;
  assign frame_o       = frame_q;

endmodule

/* rtl/core/htfd_convert.sv */
// scaling multiplies, limit checks and the result register
module htfd_convert (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  htfd_pkg::cfg_t           cfg_i,
  input  logic                     frame_valid_i,
  output logic                     frame_ready_o,
  input  htfd_pkg::frame_t         frame_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [13:0]              humidity_centi_o,
  output logic signed [14:0]       temperature_centi_o,
  output logic [1:0]               status_o
);
  import htfd_pkg::*;

  logic [33:0]        hum_prod;
  logic [34:0]        temp_prod;

  logic               scale_valid_q;
  logic [13:0]        hum_q;
  logic [14:0]        temp_scaled_q;
  logic               crc_err_q;
  logic               zero_q;

  logic               out_valid_q;
  logic [13:0]        out_hum_q;
  logic signed [14:0] out_temp_q;
  status_e            out_status_q;

  logic               out_free;
  logic               scale_free;
  logic signed [15:0] temp_full;
  logic               out_of_range;
  status_e            status_d;

  assign out_free      = !out_valid_q || out_ready_i;
  assign scale_free    = !scale_valid_q || out_free;
  assign frame_ready_o = scale_free;

  assign hum_prod  = frame_i.raw_hum * HUM_SCALE;
  assign temp_prod = frame_i.temp_raw * TEMP_SCALE;

  assign temp_full = $signed({1'b0, temp_scaled_q}) - TEMP_OFFSET;

  assign out_of_range = ({1'b0, hum_q} > {1'b0, cfg_i.hum_max})
                     || (temp_full < 16'(cfg_i.temp_min))
                     || (temp_full > 16'(cfg_i.temp_max));

  always_comb begin
    if (crc_err_q) begin
      status_d = STATUS_CRC;
    end else if (out_of_range) begin
      status_d = STATUS_RANGE;
    end else if (zero_q) begin
      status_d = STATUS_ZERO;
    end else begin
      status_d = STATUS_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_valid_q <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (scale_free) begin
        scale_valid_q <= frame_valid_i;
      end
      if (out_free) begin
        out_valid_q <= scale_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (frame_valid_i && scale_free) begin
      hum_q         <= hum_prod[33:20];
      temp_scaled_q <= temp_prod[34:20];
      crc_err_q     <= frame_i.crc_err;
      zero_q        <= (frame_i.raw_hum == 20'd0) && (frame_i.temp_raw == 20'd0);
    end
    if (scale_valid_q && out_free) begin
      out_hum_q    <= hum_q;
      out_temp_q   <= temp_full[14:0];
      out_status_q <= status_d;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign humidity_centi_o    = out_hum_q;
  assign temperature_centi_o = out_temp_q;
  assign status_o            = out_status_q;

endmodule

/* rtl/core/humidity_temp_frame_decoder.sv */
// top level: configuration registers and the frame and conversion stages
// crc byte path: frame register, conversion stage, result register
// throughput: one byte per cycle; a crc byte waits only when the frame
//   register, the conversion stage and the result register are all full
//   and the result is stalled
// reset: clears byte count, crc, raw fields and all valid flags, and loads
//   the limit registers with their defaults
module humidity_temp_frame_decoder (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               frame_start_i,
  input  logic [7:0]         data_byte_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [13:0]        humidity_centi_o,
  output logic signed [14:0] temperature_centi_o,
  output logic [1:0]         status_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [14:0]        cfg_data_i
);
  import htfd_pkg::*;

  cfg_t   cfg_q;
  logic   frame_valid;
  logic   frame_ready;
  frame_t frame;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.temp_min <= TEMP_MIN_RESET;
      cfg_q.temp_max <= TEMP_MAX_RESET;
      cfg_q.hum_max  <= HUM_MAX_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_TEMP_MIN: cfg_q.temp_min <= cfg_data_i;
        CFG_TEMP_MAX: cfg_q.temp_max <= cfg_data_i;
        CFG_HUM_MAX:  cfg_q.hum_max  <= cfg_data_i[13:0];
        default: ;
      endcase
    end
  end

  htfd_frame u_frame (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .frame_start_i (frame_start_i),
    .data_byte_i   (data_byte_i),
    .frame_valid_o (frame_valid),
    .frame_ready_i (frame_ready),
    .frame_o       (frame)
  );

  htfd_convert u_convert (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_i               (cfg_q),
    .frame_valid_i       (frame_valid),
    .frame_ready_o       (frame_ready),
    .frame_i             (frame),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .humidity_centi_o    (humidity_centi_o),
    .temperature_centi_o (temperature_centi_o),
    .status_o            (status_o)
  );

endmodule

/* verif/tb_humidity_temp_frame_decoder.sv */
// self-checking testbench for the humidity and temperature frame decoder
module tb_humidity_temp_frame_decoder;
  import htfd_pkg::*;

  localparam logic [1:0] CFG_SPARE   = 2'd3;   // index with no register behind it
  localparam int         QUIET_LIMIT = 2000;
  localparam int         HOLD_CYCLES = 200;
  localparam int         TAIL_CYCLES = 8;
  localparam int         RAND_BYTES  = 160;

  typedef struct packed {
    logic [13:0]        hum;
    logic signed [14:0] temp;
    status_e            status;
  } reading_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic               frame_start_i = 1'b0;
  logic [7:0]         data_byte_i = 8'h00;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [13:0]        humidity_centi_o;
  logic signed [14:0] temperature_centi_o;
  logic [1:0]         status_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [1:0]         cfg_index_i = 2'd0;
  logic [14:0]        cfg_data_i = 15'd0;

  // decoder state mirrored by the testbench
  logic [2:0]         frame_pos;
  logic [7:0]         crc_acc;
  logic [19:0]        hum_raw_acc;
  logic [19:0]        temp_raw_acc;
  logic signed [14:0] lim_temp_min;
  logic signed [14:0] lim_temp_max;
  logic [13:0]        lim_hum_max;

  reading_t expected_readings[$];

  bit in_idle_en  = 1'b1;
  bit out_idle_en = 1'b1;
  bit out_hold    = 1'b0;

  int mismatches;
  int bytes_sent;
  int frames_sent;
  int readings_checked;
  int limit_writes;
  int status_seen[4];
  int quiet_cycles;

  humidity_temp_frame_decoder DUT (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .frame_start_i       (frame_start_i),
    .data_byte_i         (data_byte_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .humidity_centi_o    (humidity_centi_o),
    .temperature_centi_o (temperature_centi_o),
    .status_o            (status_o),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // bit-serial crc-8, data fed msb first
  function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] r;
    logic       fb;
    r = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = r[7] ^ data[i];
      r = {r[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
    end
    return r;
  endfunction

  function automatic void reset_decoder_state();
    frame_pos    = POS_STATUS;
    crc_acc      = CRC_INIT;
    hum_raw_acc  = '0;
    temp_raw_acc = '0;
    lim_temp_min = TEMP_MIN_RESET;
    lim_temp_max = TEMP_MAX_RESET;
    lim_hum_max  = HUM_MAX_RESET;
  endfunction

  // advances the mirrored decoder by one byte, queues a reading on the crc byte
  function automatic void decode_byte(input logic start, input logic [7:0] b);
    logic [2:0] pos;
    logic [7:0] crc;
    int         hum_v;
    int         temp_v;
    reading_t   r;
    pos = start ? POS_STATUS : frame_pos;
    if (pos > POS_CRC) pos = POS_STATUS;
    crc = (pos == POS_STATUS) ? CRC_INIT : crc_acc;
    if (pos != POS_CRC) begin
      crc_acc = crc_step(crc, b);
      case (pos)
        POS_HUM_HI:   hum_raw_acc[19:12] = b;
        POS_HUM_MID:  hum_raw_acc[11:4] = b;
        POS_SPLIT: begin
          hum_raw_acc[3:0]    = b[7:4];
          temp_raw_acc[19:16] = b[3:0];
        end
        POS_TEMP_MID: temp_raw_acc[15:8] = b;
        POS_TEMP_LO:  temp_raw_acc[7:0] = b;
        default: ;
      endcase
      frame_pos = pos + 3'd1;
    end else begin
      hum_v  = int'((64'(hum_raw_acc) * 64'(HUM_SCALE)) >> 20);
      temp_v = int'((64'(temp_raw_acc) * 64'(TEMP_SCALE)) >> 20) - int'(TEMP_OFFSET);
      if (crc != b) begin
        r.status = STATUS_CRC;
      end else if (hum_v > int'(lim_hum_max) || temp_v < int'(lim_temp_min) ||
                   temp_v > int'(lim_temp_max)) begin
        r.status = STATUS_RANGE;
      end else if (hum_raw_acc == '0 && temp_raw_acc == '0) begin
        r.status = STATUS_ZERO;
      end else begin
        r.status = STATUS_OK;
      end
      r.hum  = hum_v[13:0];
      r.temp = temp_v[14:0];
      expected_readings.push_back(r);
      frame_pos = POS_STATUS;
      crc_acc   = CRC_INIT;
    end
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatches < 50) $display("mismatch at %0t: %s", $time, msg);
    mismatches++;
  endtask

  // result checker
  always @(posedge clk_i) begin
    reading_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_readings.size() == 0) begin
        report_mismatch("reading with no frame pending");
      end else begin
        want = expected_readings.pop_front();
        readings_checked++;
        status_seen[want.status]++;
        if (humidity_centi_o !== want.hum)
          report_mismatch($sformatf("humidity %0d, want %0d", humidity_centi_o, want.hum));
        if (temperature_centi_o !== want.temp)
          report_mismatch($sformatf("temperature %0d, want %0d",
                                    temperature_centi_o, want.temp));
        if (status_o !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", status_o, want.status));
      end
    end
  end

  // receiver side
  always @(posedge clk_i) begin
    if (out_hold) begin
      out_ready_i <= 1'b0;
    end else if (out_idle_en) begin
      out_ready_i <= ($urandom_range(99) >= 23);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: %0d cycles without a transaction", quiet_cycles);
      $display("tb_humidity_temp_frame_decoder failed");
      $finish;
    end
  end

  // leaves valid high after the transaction so the next byte can follow at once
  task automatic send_byte(input logic start, input logic [7:0] b);
    if (in_idle_en) begin
      while ($urandom_range(99) < 23) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i    <= 1'b1;
    frame_start_i <= start;
    data_byte_i   <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    decode_byte(start, b);
    bytes_sent++;
  endtask

  task automatic send_frame(input logic start, input logic [19:0] hr, input logic [19:0] tr,
                            input logic [7:0] sensor_status, input logic [7:0] crc_flip);
    logic [7:0] fb [0:6];
    logic [7:0] crc;
    fb[0] = sensor_status;
    fb[1] = hr[19:12];
    fb[2] = hr[11:4];
    fb[3] = {hr[3:0], tr[19:16]};
    fb[4] = tr[15:8];
    fb[5] = tr[7:0];
    crc = CRC_INIT;
    for (int i = 0; i < 6; i++) crc = crc_step(crc, fb[i]);
    fb[6] = crc ^ crc_flip;
    send_byte(start, fb[0]);
    for (int i = 1; i < 7; i++) send_byte(1'b0, fb[i]);
    frames_sent++;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [14:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CFG_TEMP_MIN: lim_temp_min = val;
      CFG_TEMP_MAX: lim_temp_max = val;
      CFG_HUM_MAX:  lim_hum_max = val[13:0];
      default: ;
    endcase
    limit_writes++;
  endtask

  task automatic set_limits(input int tmin, input int tmax, input int hmax);
    write_reg(CFG_TEMP_MIN, 15'(tmin));
    write_reg(CFG_TEMP_MAX, 15'(tmax));
    write_reg(CFG_HUM_MAX, 15'(hmax));
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // sender stops until every reading is back and the pipeline has settled
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_readings.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
  endtask

  // raw code that lands within a few counts of a given scaled value
  function automatic logic [19:0] raw_near(input int scaled, input int scale);
    longint r;
    r = (longint'(scaled) * 1048576) / scale + longint'($urandom_range(6)) - 3;
    if (r < 0) r = 0;
    if (r > 20'hFFFFF) r = 20'hFFFFF;
    return r[19:0];
  endfunction

  function automatic logic [19:0] pick_hum_raw();
    case ($urandom_range(9))
      0:       return 20'h00000;
      1:       return 20'hFFFFF;
      2, 3:    return raw_near(int'(lim_hum_max), int'(HUM_SCALE));
      default: return 20'($urandom);
    endcase
  endfunction

  function automatic logic [19:0] pick_temp_raw();
    case ($urandom_range(9))
      0:       return 20'h00000;
      1:       return 20'hFFFFF;
      2:       return raw_near(int'(lim_temp_min) + int'(TEMP_OFFSET), int'(TEMP_SCALE));
      3:       return raw_near(int'(lim_temp_max) + int'(TEMP_OFFSET), int'(TEMP_SCALE));
      default: return 20'($urandom);
    endcase
  endfunction

  task automatic send_random_frame();
    logic       start;
    logic [7:0] flip;
    start = ($urandom_range(99) < 85);
    flip  = ($urandom_range(99) < 12) ? 8'($urandom_range(1, 255)) : 8'h00;
    send_frame(start, pick_hum_raw(), pick_temp_raw(), 8'($urandom), flip);
  endtask

  task automatic random_limits();
    int a;
    int b;
    a = int'($urandom_range(20000)) - 5000;
    b = int'($urandom_range(20000)) - 5000;
    if (a > b) set_limits(b, a, int'($urandom_range(10000)));
    else set_limits(a, b, int'($urandom_range(10000)));
  endtask

  // reset limits: an all-zero frame reads -50.00 degC and is out of range
  task automatic test_reset_defaults();
    send_frame(1'b1, 20'h00000, 20'h00000, 8'h00, 8'h00);
    drain();
  endtask

  task automatic test_directed();
    set_limits(-5000, 15000, 10000);
    send_frame(1'b1, 20'h00000, 20'h00000, 8'h00, 8'h00);
    // no start flag: the count wraps after the crc byte
    send_frame(1'b0, 20'hFFFFF, 20'hFFFFF, 8'hFF, 8'h00);
    drain();
    // crc error outranks out of range
    set_limits(0, 0, 0);
    send_frame(1'b1, 20'hFFFFF, 20'hFFFFF, 8'h1C, 8'h80);
    // start flag in the middle of a frame resynchronizes the count
    send_byte(1'b1, 8'h18);
    send_byte(1'b0, 8'hA5);
    send_byte(1'b0, 8'h5A);
    send_frame(1'b1, 20'h80000, 20'h66666, 8'h1C, 8'h00);
    drain();
  endtask

  task automatic test_limit_settings();
    int settings [5][3] = '{'{-5000, 15000, 10000}, '{15000, -5000, 0}, '{0, 0, 5000},
                            '{-16384, 16383, 16383}, '{-4000, 8000, 10000}};
    for (int s = 0; s < 5; s++) begin
      if (s == 4) begin
        // the spare index must leave every limit untouched
        write_reg(CFG_SPARE, 15'($urandom));
        cfg_valid_i <= 1'b0;
        @(posedge clk_i);
      end
      set_limits(settings[s][0], settings[s][1], settings[s][2]);
      repeat (4) send_random_frame();
      drain();
    end
  endtask

  // result side holds off while frames keep arriving back to back
  task automatic test_backpressure();
    in_idle_en = 1'b0;
    fork
      begin
        out_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        out_hold <= 1'b0;
      end
    join_none
    repeat (12) send_random_frame();
    in_idle_en = 1'b1;
    drain();
  endtask

  task automatic test_random_traffic();
    int stop_at;
    for (int phase = 0; phase < 4; phase++) begin
      random_limits();
      in_idle_en  = (phase != 2);
      out_idle_en = (phase != 2);
      stop_at = bytes_sent + RAND_BYTES / 4;
      while (bytes_sent < stop_at) begin
        if ($urandom_range(99) < 80) begin
          send_random_frame();
        end else begin
          // loose bytes that break the frame alignment
          repeat ($urandom_range(1, 5)) send_byte($urandom_range(99) < 30, 8'($urandom));
        end
      end
      drain();
    end
    in_idle_en  = 1'b1;
    out_idle_en = 1'b1;
  endtask

  initial begin
    reset_decoder_state();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reset_defaults();
    test_directed();
    test_limit_settings();
    test_backpressure();
    test_random_traffic();
    drain();
    $display("covered %0d frames in %0d bytes, %0d limit writes, %0d readings checked",
             frames_sent, bytes_sent, limit_writes, readings_checked);
    $display("status mix: ok %0d, crc %0d, range %0d, zero %0d",
             status_seen[STATUS_OK], status_seen[STATUS_CRC], status_seen[STATUS_RANGE],
             status_seen[STATUS_ZERO]);
    if (mismatches == 0) begin
      $display("tb_humidity_temp_frame_decoder passed");
    end else begin
      $display("tb_humidity_temp_frame_decoder failed");
    end
    $finish;
  end

endmodule
